>>> sv/tlbs_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the table search block.
// No dependencies; the other files that use it refer to this package by scoped names.

package tlbs_pkg;

   // Width of the location field in a result word
   localparam int LOC_W = 7;

   // Request kinds carried in req_type
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   // Search mode register codes
   localparam logic MODE_LINEAR = 1'b0;
   localparam logic MODE_BINARY = 1'b1;

   // Input word
   typedef struct packed {
      logic               req_type;
      logic               start_new;
      logic signed [31:0] value;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic             found;
      logic [LOC_W-1:0] location;
      logic             last;
   } rsp_word_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIN_ADDR,
      ST_LIN_CMP,
      ST_LIN_END,
      ST_BIN_ADDR,
      ST_BIN_CMP
   } state_type;

   // Which result word the datapath builds on an emit
   typedef enum logic [1:0] {
      RSP_LIN_MORE,
      RSP_LIN_END,
      RSP_BIN_HIT,
      RSP_MISS
   } emit_kind_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic          load;
      logic          search;
      logic          lin_rd;
      logic          lin_adv;
      logic          bin_rd;
      logic          bin_adv;
      logic          emit;
      emit_kind_type emit_kind;
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free;
      logic scan_done;
      logic range_empty;
      logic rd_match;
      logic pend_valid;
   } dp_stat_type;

endpackage

>>> sv/tlbs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module tlbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; hold the last word when not reading
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tlbs_ctrl.sv
`timescale 1ns / 1ps
// Controller for the table search block: state machine and mode register.
// Depends on tlbs_pkg.

module tlbs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_kind,
   output logic                   req_stall,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data,
   input  tlbs_pkg::dp_stat_type  stat,
   output tlbs_pkg::dp_cmd_type   cmd
);

   tlbs_pkg::state_type state_ff, state_in;
   logic                search_mode_ff, search_mode_in;

   // Mode register
   always_comb begin
      search_mode_in = search_mode_ff;
      if (csr_wr_en) begin
         search_mode_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tlbs_pkg::ST_IDLE;
         search_mode_ff <= tlbs_pkg::MODE_LINEAR;
      end else begin
         state_ff       <= state_in;
         search_mode_ff <= search_mode_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlbs_pkg::ST_IDLE: begin
            if (req_valid && req_kind == tlbs_pkg::REQ_SEARCH) begin
               state_in = (search_mode_ff == tlbs_pkg::MODE_BINARY) ?
                          tlbs_pkg::ST_BIN_ADDR : tlbs_pkg::ST_LIN_ADDR;
            end
         end
         tlbs_pkg::ST_LIN_ADDR: begin
            state_in = stat.scan_done ? tlbs_pkg::ST_LIN_END : tlbs_pkg::ST_LIN_CMP;
         end
         tlbs_pkg::ST_LIN_CMP: begin
            if (!(stat.rd_match && stat.pend_valid && !stat.out_free)) begin
               state_in = tlbs_pkg::ST_LIN_ADDR;
            end
         end
         tlbs_pkg::ST_LIN_END: begin
            if (stat.out_free) begin
               state_in = tlbs_pkg::ST_IDLE;
            end
         end
         tlbs_pkg::ST_BIN_ADDR: begin
            if (!stat.range_empty) begin
               state_in = tlbs_pkg::ST_BIN_CMP;
            end else if (stat.out_free) begin
               state_in = tlbs_pkg::ST_IDLE;
            end
         end
         tlbs_pkg::ST_BIN_CMP: begin
            if (!stat.rd_match) begin
               state_in = tlbs_pkg::ST_BIN_ADDR;
            end else if (stat.out_free) begin
               state_in = tlbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tlbs_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands and input stall
   always_comb begin
      cmd           = '0;
      cmd.emit_kind = tlbs_pkg::RSP_MISS;
      req_stall     = 1'b1;
      unique case (state_ff)
         tlbs_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.load   = req_valid && req_kind == tlbs_pkg::REQ_LOAD;
            cmd.search = req_valid && req_kind == tlbs_pkg::REQ_SEARCH;
         end
         tlbs_pkg::ST_LIN_ADDR: begin
            cmd.lin_rd = !stat.scan_done;
         end
         tlbs_pkg::ST_LIN_CMP: begin
            // A second match pushes out the one held back
            if (stat.rd_match && stat.pend_valid) begin
               cmd.emit      = stat.out_free;
               cmd.emit_kind = tlbs_pkg::RSP_LIN_MORE;
               cmd.lin_adv   = stat.out_free;
            end else begin
               cmd.lin_adv = 1'b1;
            end
         end
         tlbs_pkg::ST_LIN_END: begin
            cmd.emit      = stat.out_free;
            cmd.emit_kind = tlbs_pkg::RSP_LIN_END;
         end
         tlbs_pkg::ST_BIN_ADDR: begin
            if (stat.range_empty) begin
               cmd.emit      = stat.out_free;
               cmd.emit_kind = tlbs_pkg::RSP_MISS;
            end else begin
               cmd.bin_rd = 1'b1;
            end
         end
         tlbs_pkg::ST_BIN_CMP: begin
            if (stat.rd_match) begin
               cmd.emit      = stat.out_free;
               cmd.emit_kind = tlbs_pkg::RSP_BIN_HIT;
            end else begin
               cmd.bin_adv = 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

>>> sv/tlbs_dp.sv
`timescale 1ns / 1ps
// Datapath for the table search block: table RAM, count, scan index,
// binary bounds, held-back match and the output register.
// Depends on tlbs_pkg and tlbs_ram.

module tlbs_dp #(
   parameter int DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tlbs_pkg::req_word_type req_data,
   input  tlbs_pkg::dp_cmd_type   cmd,
   output tlbs_pkg::dp_stat_type  stat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tlbs_pkg::rsp_word_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int BW = $clog2(DEPTH + 2);
   localparam int LW = tlbs_pkg::LOC_W;

   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [BW-1:0]          lo_ff, lo_in;
   logic [BW-1:0]          hi_ff, hi_in;
   logic [BW-1:0]          mid_ff, mid_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [CW-1:0]          pend_loc_ff, pend_loc_in;
   logic signed [31:0]     key_ff, key_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tlbs_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [31:0]            rd_data;
   logic [BW:0]            bound_sum;
   logic [BW-1:0]          mid_calc;
   logic [BW-1:0]          mid_less;
   logic [CW-1:0]          idx_next;
   logic                   key_less;
   logic [BW+LW-1:0]       pend_wide;
   logic [BW+LW-1:0]       mid_wide;

   // Table store
   tlbs_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Load: a start word restarts at entry zero, a full table drops the word
   assign wr_en   = cmd.load && (req_data.start_new || count_ff != CW'(DEPTH));
   assign wr_addr = req_data.start_new ? '0 : count_ff[AW-1:0];

   // Probe address generation
   assign bound_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc  = bound_sum[BW:1];
   assign mid_less  = mid_calc - BW'(1);
   assign rd_en     = cmd.lin_rd || cmd.bin_rd;
   assign rd_addr   = cmd.bin_rd ? mid_less[AW-1:0] : idx_ff[AW-1:0];

   assign idx_next = idx_ff + CW'(1);
   assign key_less = key_ff < $signed(rd_data);

   // Status back to the controller
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;
   assign stat.scan_done   = idx_ff == count_ff;
   assign stat.range_empty = lo_ff > hi_ff;
   assign stat.rd_match    = $signed(rd_data) == key_ff;
   assign stat.pend_valid  = pend_valid_ff;

   // Count, scan and bound updates
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      pend_valid_in = pend_valid_ff;
      pend_loc_in   = pend_loc_ff;
      key_in        = key_ff;
      if (cmd.load) begin
         if (req_data.start_new) begin
            count_in = CW'(1);
         end else if (count_ff != CW'(DEPTH)) begin
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.search) begin
         key_in        = req_data.value;
         idx_in        = '0;
         lo_in         = BW'(1);
         hi_in         = BW'(count_ff);
         pend_valid_in = 1'b0;
      end
      if (cmd.lin_adv) begin
         idx_in = idx_next;
         if (stat.rd_match) begin
            pend_valid_in = 1'b1;
            pend_loc_in   = idx_next;
         end
      end
      if (cmd.bin_rd) begin
         mid_in = mid_calc;
      end
      if (cmd.bin_adv) begin
         if (key_less) begin
            hi_in = mid_ff - BW'(1);
         end else begin
            lo_in = mid_ff + BW'(1);
         end
      end
   end

   // Build the result word
   assign pend_wide = (BW + LW)'(pend_loc_ff);
   assign mid_wide  = (BW + LW)'(mid_ff);

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         unique case (cmd.emit_kind)
            tlbs_pkg::RSP_LIN_MORE: begin
               rsp_data_in.found    = 1'b1;
               rsp_data_in.location = pend_wide[LW-1:0];
               rsp_data_in.last     = 1'b0;
            end
            tlbs_pkg::RSP_LIN_END: begin
               rsp_data_in.found    = pend_valid_ff;
               rsp_data_in.location = pend_valid_ff ? pend_wide[LW-1:0] : '0;
               rsp_data_in.last     = 1'b1;
            end
            tlbs_pkg::RSP_BIN_HIT: begin
               rsp_data_in.found    = 1'b1;
               rsp_data_in.location = mid_wide[LW-1:0];
               rsp_data_in.last     = 1'b1;
            end
            tlbs_pkg::RSP_MISS: begin
               rsp_data_in.found    = 1'b0;
               rsp_data_in.location = '0;
               rsp_data_in.last     = 1'b1;
            end
            default: begin
               rsp_data_in = rsp_data_ff;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      pend_loc_ff <= pend_loc_in;
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A word is only pushed into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("result word emitted while output register is held");

   // The count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count beyond table depth");

   // A linear probe only reads loaded entries
   a_lin_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.lin_rd |-> idx_ff < count_ff)
      else $error("linear probe beyond loaded entries");

   // A binary probe only happens on a non-empty range
   a_bin_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.bin_rd |-> (mid_calc >= BW'(1) && mid_calc <= BW'(count_ff)))
      else $error("binary probe outside loaded entries");

endmodule

>>> sv/table_linear_binary_search.sv
`timescale 1ns / 1ps
// Table with linear and binary search. A linear search reads each loaded
// element in turn through the registered read port of the single table RAM;
// a binary search makes at most log2(DEPTH)+1 probes, each a read and a
// compare. One word is worked on at a time; the next word is taken the
// cycle after the final result word is registered. Reset clears the element
// count, the mode and the output valid; the table contents are not cleared
// and need no clearing pass.

module table_linear_binary_search #(
   parameter int DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tlbs_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tlbs_pkg::rsp_word_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data
);

   tlbs_pkg::dp_cmd_type  cmd;
   tlbs_pkg::dp_stat_type stat;

   // Sequencer
   tlbs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_kind    (req_data.req_type),
      .req_stall   (req_stall),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stat        (stat),
      .cmd         (cmd)
   );

   // Table, counters and output register
   tlbs_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
